@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl files
// each macro expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define HCA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen
`define HCA_ASSERT_NEVER(lbl, cond, msg) \
	`HCA_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/core/hca_pkg.sv @@
// ----------------------------------------------------------------------------
// hca_pkg
// Types, codes and helpers of the hierarchical credit admission unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hca_pkg;

	localparam int OWNER_SLOTS_DEF = 16;

	localparam logic [15:0] OWNER_TASK_LIMIT_RST = 16'd64;
	localparam logic [31:0] OWNER_BYTE_LIMIT_RST = 32'd1048576;
	localparam logic [31:0] GLOBAL_BYTE_LIMIT_RST = 32'd16777216;
	localparam logic [31:0] LOW_BYTE_LIMIT_RST = 32'd8388608;

	// operations
	localparam logic [1:0] OP_RESERVE = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_SHUTDOWN = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	// result reasons
	localparam logic [2:0] RSN_OK = 3'd0;
	localparam logic [2:0] RSN_SHUT_DOWN = 3'd1;
	localparam logic [2:0] RSN_OWNER_TASKS = 3'd2;
	localparam logic [2:0] RSN_OWNER_BYTES = 3'd3;
	localparam logic [2:0] RSN_LOW_SOFT = 3'd4;
	localparam logic [2:0] RSN_GLOBAL_BYTES = 3'd5;
	localparam logic [2:0] RSN_TABLE_FULL = 3'd6;
	localparam logic [2:0] RSN_RELEASE_ERR = 3'd7;

	// configuration register indexes
	localparam logic [1:0] CFG_OWNER_TASK_LIMIT = 2'd0;
	localparam logic [1:0] CFG_OWNER_BYTE_LIMIT = 2'd1;
	localparam logic [1:0] CFG_GLOBAL_BYTE_LIMIT = 2'd2;
	localparam logic [1:0] CFG_LOW_BYTE_LIMIT = 2'd3;

	typedef struct packed {
		logic [15:0] tasks;
		logic [31:0] bytes;
		logic [15:0] peak_tasks;
		logic [31:0] peak_bytes;
		logic [31:0] task_rejects;
		logic [31:0] byte_rejects;
	} entry_t;

	typedef struct packed {
		logic [31:0] tasks;
		logic [31:0] bytes;
		logic [31:0] peak_bytes;
		logic [31:0] byte_rejects;
	} totals_t;

	typedef struct packed {
		logic [15:0] task_limit;
		logic [31:0] byte_limit;
		logic [31:0] global_limit;
		logic [31:0] low_limit;
	} limits_t;

	typedef struct packed {
		logic hit;
		logic has_free;
	} cam_status_t;

	typedef struct packed {
		logic entry_we;
		logic alloc;
		logic slot_ok;
	} eval_ctl_t;

	typedef struct packed {
		logic [2:0] reason;
		entry_t     owner;
		totals_t    totals;
		logic       accepting;
	} result_t;

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/hca_owner_cam.sv @@
// ----------------------------------------------------------------------------
// hca_owner_cam
// Owner id table: parallel match and lowest free slot search.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hca_owner_cam import hca_pkg::*; #(
	parameter int SLOTS = OWNER_SLOTS_DEF,
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [63:0]       lookup_id,
	input  wire logic              alloc_en,
	output cam_status_t            status,
	output logic      [SLOT_W-1:0] hit_idx,
	output logic      [SLOT_W-1:0] free_idx
);

	logic [SLOTS-1:0] valid_q;
	logic [63:0]      owner_q [SLOTS];
	logic [SLOTS-1:0] match;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = valid_q[i] && (owner_q[i] == lookup_id);
		end
	end

	// lowest index wins for both searches
	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
		status.hit = |match;
		status.has_free = ~&valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (alloc_en) begin
			valid_q[free_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_en) begin
			owner_q[free_idx] <= lookup_id;
		end
	end

	`HCA_ASSERT(a_owner_unique, $onehot0(match), "owner id held by more than one slot")
	`HCA_ASSERT_NEVER(a_alloc_when_full, alloc_en && !status.has_free, "allocation with no free slot")

endmodule

`default_nettype wire

@@ rtl/core/hca_entry_store.sv @@
// ----------------------------------------------------------------------------
// hca_entry_store
// Per-owner counters, one read and one write at the selected slot.
// ----------------------------------------------------------------------------
`default_nettype none

module hca_entry_store import hca_pkg::*; #(
	parameter int SLOTS = OWNER_SLOTS_DEF,
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [SLOT_W-1:0] idx,
	input  wire entry_t            wdata,
	output entry_t                 rdata
);

	entry_t entry_q [SLOTS];

	assign rdata = entry_q[idx];

	// slots are zeroed on allocation, so no reset is needed
	always_ff @(posedge clk) begin
		if (we) begin
			entry_q[idx] <= wdata;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/hca_credit_eval.sv @@
// ----------------------------------------------------------------------------
// hca_credit_eval
// Credit checks, rollback, peaks and release for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module hca_credit_eval import hca_pkg::*; (
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] request_bytes,
	input  wire logic        low_priority,
	input  wire cam_status_t status,
	input  wire entry_t      cur_entry,
	input  wire totals_t     cur_totals,
	input  wire logic        admit,
	input  wire limits_t     limits,
	output entry_t           nxt_entry,
	output totals_t          nxt_totals,
	output logic             nxt_admit,
	output logic [2:0]       reason,
	output eval_ctl_t        ctl
);

	logic [32:0] own_sum;
	logic [32:0] glb_sum;
	logic [31:0] sel_limit;
	logic        own_fit;
	logic        glb_fit;
	logic        full_fit;
	logic        task_fit;
	logic [15:0] tasks_inc;
	logic        nz;
	logic        under_gb;
	logic        under_eb;
	logic        under_et;
	logic        under_gt;
	logic        slot_ok;

	always_comb begin
		own_sum = {1'b0, cur_entry.bytes} + {1'b0, request_bytes};
		glb_sum = {1'b0, cur_totals.bytes} + {1'b0, request_bytes};
		sel_limit = low_priority ? limits.low_limit : limits.global_limit;
		own_fit = own_sum <= {1'b0, limits.byte_limit};
		glb_fit = glb_sum <= {1'b0, sel_limit};
		full_fit = glb_sum <= {1'b0, limits.global_limit};
		task_fit = cur_entry.tasks < limits.task_limit;
		tasks_inc = cur_entry.tasks + 16'd1;
		nz = request_bytes != 32'd0;
		under_gb = nz && (cur_totals.bytes < request_bytes);
		under_eb = nz && (cur_entry.bytes < request_bytes);
		under_et = cur_entry.tasks == 16'd0;
		under_gt = cur_totals.tasks == 32'd0;
		slot_ok = status.hit || ((operation == OP_RESERVE) && status.has_free);

		nxt_entry = cur_entry;
		nxt_totals = cur_totals;
		nxt_admit = admit;
		reason = RSN_OK;
		ctl.entry_we = 1'b0;
		ctl.alloc = 1'b0;
		ctl.slot_ok = slot_ok;

		unique case (operation)
			OP_RESERVE: begin
				if (!slot_ok) begin
					reason = RSN_TABLE_FULL;
				end else begin
					ctl.entry_we = 1'b1;
					ctl.alloc = !status.hit;
					if (!admit) begin
						reason = RSN_SHUT_DOWN;
					end else if (!task_fit) begin
						nxt_entry.task_rejects = sat_inc32(cur_entry.task_rejects);
						reason = RSN_OWNER_TASKS;
					end else begin
						// task peak stays raised even when a byte stage rolls back
						if (tasks_inc > cur_entry.peak_tasks) begin
							nxt_entry.peak_tasks = tasks_inc;
						end
						if (nz && !own_fit) begin
							nxt_entry.byte_rejects = sat_inc32(cur_entry.byte_rejects);
							reason = RSN_OWNER_BYTES;
						end else if (nz && !glb_fit) begin
							if (own_sum[31:0] > cur_entry.peak_bytes) begin
								nxt_entry.peak_bytes = own_sum[31:0];
							end
							nxt_totals.byte_rejects = sat_inc32(cur_totals.byte_rejects);
							reason = (low_priority && full_fit) ? RSN_LOW_SOFT
								: RSN_GLOBAL_BYTES;
						end else begin
							nxt_entry.tasks = tasks_inc;
							if (nz) begin
								nxt_entry.bytes = own_sum[31:0];
								if (own_sum[31:0] > cur_entry.peak_bytes) begin
									nxt_entry.peak_bytes = own_sum[31:0];
								end
								nxt_totals.bytes = glb_sum[31:0];
								if (glb_sum[31:0] > cur_totals.peak_bytes) begin
									nxt_totals.peak_bytes = glb_sum[31:0];
								end
							end
							nxt_totals.tasks = sat_inc32(cur_totals.tasks);
						end
					end
				end
			end
			OP_RELEASE: begin
				if (!status.hit) begin
					reason = RSN_RELEASE_ERR;
				end else begin
					ctl.entry_we = 1'b1;
					// counters that would underflow stop at zero
					if (nz) begin
						nxt_totals.bytes = under_gb ? 32'd0
							: cur_totals.bytes - request_bytes;
						nxt_entry.bytes = under_eb ? 32'd0
							: cur_entry.bytes - request_bytes;
					end
					nxt_entry.tasks = under_et ? 16'd0 : cur_entry.tasks - 16'd1;
					nxt_totals.tasks = under_gt ? 32'd0 : cur_totals.tasks - 32'd1;
					if (under_gb || under_eb || under_et || under_gt) begin
						reason = RSN_RELEASE_ERR;
					end
				end
			end
			OP_SHUTDOWN: begin
				nxt_admit = 1'b0;
			end
			OP_QUERY: begin
				nxt_admit = admit;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/hierarchical_credit_admission_unit.sv @@
// ----------------------------------------------------------------------------
// hierarchical_credit_admission_unit
// Owner and global credit admission with reserve, release, shutdown, query.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid, in_stall   operation, owner_id, request_bytes,
//                                            low_priority
//  out       source     out_valid, out_stall reason, owner_* and total_*
//                                            counters, accepting_now
//  cfg       sink       cfg_we               cfg_index, cfg_data
//
//  one beat per cycle while out_stall is low; a beat enters the input register,
//  is evaluated against the owner table and counters, and lands in the result
//  register once it is empty or not stalled. the owner match, credit adds and
//  compares of one request sit in the single stage between those registers.
//  reset clears the owner valid bits and global counters, reopens admission
//  and loads default limits. a stalled result holds the result register, and
//  in_stall rises once the input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hierarchical_credit_admission_unit import hca_pkg::*; #(
	parameter int OWNER_SLOTS = OWNER_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [63:0] owner_id,
	input  wire logic [31:0] request_bytes,
	input  wire logic        low_priority,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       reason,
	output logic [15:0]      owner_tasks,
	output logic [31:0]      owner_bytes,
	output logic [15:0]      owner_peak_tasks,
	output logic [31:0]      owner_peak_bytes,
	output logic [31:0]      owner_task_rejects,
	output logic [31:0]      owner_byte_rejects,
	output logic [31:0]      total_tasks,
	output logic [31:0]      total_bytes,
	output logic [31:0]      total_peak_bytes,
	output logic [31:0]      total_byte_rejects,
	output logic             accepting_now,

	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int SLOT_W = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [63:0] owner_id_s1;
	logic [31:0] bytes_s1;
	logic        low_s1;

	logic        out_valid_q;
	result_t     out_q;

	limits_t     limits_q;
	totals_t     totals_q;
	logic        admit_q;

	logic        advance;
	logic        load_s1;

	cam_status_t     status;
	logic [SLOT_W-1:0] hit_idx;
	logic [SLOT_W-1:0] free_idx;
	logic [SLOT_W-1:0] slot_idx;
	entry_t          rd_entry;
	entry_t          cur_entry;
	entry_t          nxt_entry;
	totals_t         nxt_totals;
	logic            nxt_admit;
	logic [2:0]      nxt_reason;
	eval_ctl_t       ctl;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign load_s1 = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1 <= operation;
			owner_id_s1 <= owner_id;
			bytes_s1 <= request_bytes;
			low_s1 <= low_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.task_limit <= OWNER_TASK_LIMIT_RST;
			limits_q.byte_limit <= OWNER_BYTE_LIMIT_RST;
			limits_q.global_limit <= GLOBAL_BYTE_LIMIT_RST;
			limits_q.low_limit <= LOW_BYTE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWNER_TASK_LIMIT: limits_q.task_limit <= cfg_data[15:0];
				CFG_OWNER_BYTE_LIMIT: limits_q.byte_limit <= cfg_data;
				CFG_GLOBAL_BYTE_LIMIT: limits_q.global_limit <= cfg_data;
				CFG_LOW_BYTE_LIMIT: limits_q.low_limit <= cfg_data;
			endcase
		end
	end

	hca_owner_cam #(
		.SLOTS(OWNER_SLOTS)
	) u_cam (
		.clk(clk),
		.arst_n(arst_n),
		.lookup_id(owner_id_s1),
		.alloc_en(advance && ctl.alloc),
		.status(status),
		.hit_idx(hit_idx),
		.free_idx(free_idx)
	);

	assign slot_idx = status.hit ? hit_idx : free_idx;

	hca_entry_store #(
		.SLOTS(OWNER_SLOTS)
	) u_store (
		.clk(clk),
		.we(advance && ctl.entry_we),
		.idx(slot_idx),
		.wdata(nxt_entry),
		.rdata(rd_entry)
	);

	// a newly allocated slot starts from zero counters
	assign cur_entry = status.hit ? rd_entry : '0;

	hca_credit_eval u_eval (
		.operation(op_s1),
		.request_bytes(bytes_s1),
		.low_priority(low_s1),
		.status(status),
		.cur_entry(cur_entry),
		.cur_totals(totals_q),
		.admit(admit_q),
		.limits(limits_q),
		.nxt_entry(nxt_entry),
		.nxt_totals(nxt_totals),
		.nxt_admit(nxt_admit),
		.reason(nxt_reason),
		.ctl(ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			totals_q <= '0;
			admit_q <= 1'b1;
		end else if (advance) begin
			totals_q <= nxt_totals;
			admit_q <= nxt_admit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.reason <= nxt_reason;
			out_q.owner <= ctl.slot_ok ? nxt_entry : '0;
			out_q.totals <= nxt_totals;
			out_q.accepting <= nxt_admit;
		end
	end

	assign out_valid = out_valid_q;
	assign reason = out_q.reason;
	assign owner_tasks = out_q.owner.tasks;
	assign owner_bytes = out_q.owner.bytes;
	assign owner_peak_tasks = out_q.owner.peak_tasks;
	assign owner_peak_bytes = out_q.owner.peak_bytes;
	assign owner_task_rejects = out_q.owner.task_rejects;
	assign owner_byte_rejects = out_q.owner.byte_rejects;
	assign total_tasks = out_q.totals.tasks;
	assign total_bytes = out_q.totals.bytes;
	assign total_peak_bytes = out_q.totals.peak_bytes;
	assign total_byte_rejects = out_q.totals.byte_rejects;
	assign accepting_now = out_q.accepting;

	`HCA_ASSERT(a_admit_sticky, !admit_q |=> !admit_q, "admission reopened after shutdown")
	`HCA_ASSERT(a_shutdown_beat, advance && (op_s1 == OP_SHUTDOWN) |=> out_valid_q && !out_q.accepting, "shutdown beat still shows accepting")
	`HCA_ASSERT_NEVER(a_full_owner_fields, out_valid_q && (out_q.reason == RSN_TABLE_FULL) && (out_q.owner != '0), "table full beat carries owner counters")

endmodule

`default_nettype wire
